/* rtl/quaternion_arithmetic_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros used by the quaternion unit top level
// ---------------------------------------------------------------------------
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication
`define QAU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion unit: implication check failed");

// Delayed implication; the gap argument sets how far past the next edge the consequent lands
`define QAU_ASSERT_AFTER(label, clk, rst, ante, gap, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##gap (cons)) \
      else $error("quaternion unit: latency check failed");

`endif

/* rtl/qau_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_pkg
// Widths, command codes and lane types for the quaternion unit.
// ---------------------------------------------------------------------------
package qau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int CMD_WIDTH  = 4;
   localparam int TOL_WIDTH  = 8;
   localparam int NUM_LANES  = 4;
   localparam int NUM_TERMS  = 4;

   // x operand carries its sign change, so one extra bit
   localparam int XW         = DATA_WIDTH + 1;
   localparam int PROD_WIDTH = XW + DATA_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + $clog2(NUM_TERMS);

   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD     = 4'd0,
      CMD_SUB     = 4'd1,
      CMD_MUL     = 4'd2,
      CMD_NEG     = 4'd3,
      CMD_CONJ    = 4'd4,
      CMD_SCALE   = 4'd5,
      CMD_ADDREAL = 4'd6,
      CMD_DOT     = 4'd7,
      CMD_CROSS   = 4'd8,
      CMD_NORMSQ  = 4'd9,
      CMD_EQUAL   = 4'd10,
      CMD_NONZERO = 4'd11
   } cmd_type;

   // one signed product term: x (already negated if needed) times y
   typedef struct packed {
      logic [XW-1:0]         x;
      logic [DATA_WIDTH-1:0] y;
   } term_type;

   typedef struct packed {
      term_type [NUM_TERMS-1:0] terms;
      logic                     frac_shift;
   } lane_op_type;

   typedef struct packed {
      logic use_sum;
      logic flag;
   } item_info_type;

   typedef struct packed {
      logic                  sat;
      logic [DATA_WIDTH-1:0] value;
   } lane_res_type;

   typedef struct packed {
      logic mul;
      logic sum;
   } stage_en_type;

   localparam data_type ONE = data_type'(1);

   function automatic term_type make_term(data_type x, data_type y, logic neg);
      logic [XW-1:0] xe;
      term_type      t;
      xe  = {x[DATA_WIDTH-1], x};
      t.x = neg ? (~xe + XW'(1)) : xe;
      t.y = y;
      return t;
   endfunction

endpackage

/* rtl/qau_decode.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_decode
// Turns a request into four product-term lists and evaluates the tests.
// ---------------------------------------------------------------------------
module qau_decode (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      accept,
   input  logic [qau_pkg::CMD_WIDTH-1:0]             req_cmd,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_p_a,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_p_b,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_p_c,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_p_d,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_q_a,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_q_b,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_q_c,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_q_d,
   input  logic [qau_pkg::DATA_WIDTH-1:0]            req_scalar,
   input  logic [qau_pkg::TOL_WIDTH-1:0]             tolerance,
   output logic                                      valid_ff,
   output qau_pkg::lane_op_type [qau_pkg::NUM_LANES-1:0] ops_ff,
   output qau_pkg::item_info_type                    info_ff
);
   import qau_pkg::*;

   data_type                     p [NUM_LANES];
   data_type                     q [NUM_LANES];
   lane_op_type [NUM_LANES-1:0]  ops_in;
   item_info_type                info_in;
   logic [DATA_WIDTH:0]          diff [NUM_LANES];
   logic [DATA_WIDTH:0]          mag  [NUM_LANES];
   logic [NUM_LANES-1:0]         close;

   assign p[0] = req_p_a;
   assign p[1] = req_p_b;
   assign p[2] = req_p_c;
   assign p[3] = req_p_d;
   assign q[0] = req_q_a;
   assign q[1] = req_q_b;
   assign q[2] = req_q_c;
   assign q[3] = req_q_d;

   // component-wise |p - q| against the tolerance
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         diff[i]  = {p[i][DATA_WIDTH-1], p[i]} - {q[i][DATA_WIDTH-1], q[i]};
         mag[i]   = diff[i][DATA_WIDTH] ? (~diff[i] + (DATA_WIDTH+1)'(1)) : diff[i];
         close[i] = (mag[i] <= (DATA_WIDTH+1)'(tolerance));
      end
   end

   always_comb begin
      ops_in          = '0;
      info_in.use_sum = 1'b1;
      info_in.flag    = 1'b0;
      unique case (cmd_type'(req_cmd))
         CMD_ADD: begin
            for (int i = 0; i < NUM_LANES; i++) begin
               ops_in[i].terms[0] = make_term(p[i], ONE, 1'b0);
               ops_in[i].terms[1] = make_term(q[i], ONE, 1'b0);
            end
         end
         CMD_SUB: begin
            for (int i = 0; i < NUM_LANES; i++) begin
               ops_in[i].terms[0] = make_term(p[i], ONE, 1'b0);
               ops_in[i].terms[1] = make_term(q[i], ONE, 1'b1);
            end
         end
         CMD_MUL: begin
            for (int i = 0; i < NUM_LANES; i++) ops_in[i].frac_shift = 1'b1;
            ops_in[0].terms[0] = make_term(p[0], q[0], 1'b0);
            ops_in[0].terms[1] = make_term(p[1], q[1], 1'b1);
            ops_in[0].terms[2] = make_term(p[2], q[2], 1'b1);
            ops_in[0].terms[3] = make_term(p[3], q[3], 1'b1);
            ops_in[1].terms[0] = make_term(p[0], q[1], 1'b0);
            ops_in[1].terms[1] = make_term(p[1], q[0], 1'b0);
            ops_in[1].terms[2] = make_term(p[2], q[3], 1'b0);
            ops_in[1].terms[3] = make_term(p[3], q[2], 1'b1);
            ops_in[2].terms[0] = make_term(p[0], q[2], 1'b0);
            ops_in[2].terms[1] = make_term(p[1], q[3], 1'b1);
            ops_in[2].terms[2] = make_term(p[2], q[0], 1'b0);
            ops_in[2].terms[3] = make_term(p[3], q[1], 1'b0);
            ops_in[3].terms[0] = make_term(p[0], q[3], 1'b0);
            ops_in[3].terms[1] = make_term(p[1], q[2], 1'b0);
            ops_in[3].terms[2] = make_term(p[2], q[1], 1'b1);
            ops_in[3].terms[3] = make_term(p[3], q[0], 1'b0);
         end
         CMD_NEG: begin
            for (int i = 0; i < NUM_LANES; i++)
               ops_in[i].terms[0] = make_term(p[i], ONE, 1'b1);
         end
         CMD_CONJ: begin
            ops_in[0].terms[0] = make_term(p[0], ONE, 1'b0);
            for (int i = 1; i < NUM_LANES; i++)
               ops_in[i].terms[0] = make_term(p[i], ONE, 1'b1);
         end
         CMD_SCALE: begin
            for (int i = 0; i < NUM_LANES; i++) begin
               ops_in[i].frac_shift = 1'b1;
               ops_in[i].terms[0]   = make_term(p[i], req_scalar, 1'b0);
            end
         end
         CMD_ADDREAL: begin
            ops_in[0].terms[1] = make_term(req_scalar, ONE, 1'b0);
            for (int i = 0; i < NUM_LANES; i++)
               ops_in[i].terms[0] = make_term(p[i], ONE, 1'b0);
         end
         CMD_DOT: begin
            ops_in[0].frac_shift = 1'b1;
            for (int i = 1; i < NUM_LANES; i++)
               ops_in[0].terms[i] = make_term(p[i], q[i], 1'b0);
         end
         CMD_CROSS: begin
            for (int i = 1; i < NUM_LANES; i++) ops_in[i].frac_shift = 1'b1;
            ops_in[1].terms[0] = make_term(p[2], q[3], 1'b0);
            ops_in[1].terms[1] = make_term(p[3], q[2], 1'b1);
            ops_in[2].terms[0] = make_term(p[3], q[1], 1'b0);
            ops_in[2].terms[1] = make_term(p[1], q[3], 1'b1);
            ops_in[3].terms[0] = make_term(p[1], q[2], 1'b0);
            ops_in[3].terms[1] = make_term(p[2], q[1], 1'b1);
         end
         CMD_NORMSQ: begin
            ops_in[0].frac_shift = 1'b1;
            for (int i = 0; i < NUM_LANES; i++)
               ops_in[0].terms[i] = make_term(p[i], p[i], 1'b0);
         end
         CMD_EQUAL: begin
            info_in.use_sum = 1'b0;
            info_in.flag    = &close;
         end
         CMD_NONZERO: begin
            info_in.use_sum = 1'b0;
            info_in.flag    = |{p[0], p[1], p[2], p[3]};
         end
         default: begin
            info_in.use_sum = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ops_ff  <= ops_in;
         info_ff <= info_in;
      end
   end

endmodule

/* rtl/qau_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_lane
// One component: four products, then sum, optional fraction shift, clip.
// ---------------------------------------------------------------------------
module qau_lane (
   input  logic                  clock,
   input  qau_pkg::stage_en_type en,
   input  qau_pkg::lane_op_type  op,
   output qau_pkg::lane_res_type res_ff
);
   import qau_pkg::*;

   localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
      $signed({{(SUM_WIDTH-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}});
   localparam logic signed [SUM_WIDTH-1:0] SAT_MIN = -SAT_MAX - SUM_WIDTH'(1);

   logic signed [PROD_WIDTH-1:0] prod_ff [NUM_TERMS];
   logic                         frac_ff;
   logic signed [SUM_WIDTH-1:0]  sum;
   logic signed [SUM_WIDTH-1:0]  shifted;
   lane_res_type                 res_in;

   // product stage
   always_ff @(posedge clock) begin
      if (en.mul) begin
         for (int k = 0; k < NUM_TERMS; k++)
            prod_ff[k] <= $signed(op.terms[k].x) * $signed(op.terms[k].y);
         frac_ff <= op.frac_shift;
      end
   end

   always_comb begin
      sum = '0;
      for (int k = 0; k < NUM_TERMS; k++)
         sum = sum + SUM_WIDTH'(prod_ff[k]);
      shifted = frac_ff ? (sum >>> FRAC_BITS) : sum;
      priority if (shifted > SAT_MAX) begin
         res_in.value = SAT_MAX[DATA_WIDTH-1:0];
         res_in.sat   = 1'b1;
      end else if (shifted < SAT_MIN) begin
         res_in.value = SAT_MIN[DATA_WIDTH-1:0];
         res_in.sat   = 1'b1;
      end else begin
         res_in.value = shifted[DATA_WIDTH-1:0];
         res_in.sat   = 1'b0;
      end
   end

   // sum and clip stage
   always_ff @(posedge clock) begin
      if (en.sum) begin
         res_ff <= res_in;
      end
   end

endmodule

/* rtl/qau_merge.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qau_merge
// Joins the lane results with the test flag into the registered response.
// ---------------------------------------------------------------------------
module qau_merge (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         valid,
   input  qau_pkg::lane_res_type [qau_pkg::NUM_LANES-1:0] lanes,
   input  qau_pkg::item_info_type                       info,
   output logic                                         strobe_ff,
   output qau_pkg::data_type [qau_pkg::NUM_LANES-1:0]   r_ff,
   output logic                                         sat_ff,
   output logic                                         flag_ff
);
   import qau_pkg::*;

   data_type [NUM_LANES-1:0] r_in;
   logic                     sat_in;
   logic                     any_sat;

   always_comb begin
      any_sat = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         r_in[i] = info.use_sum ? lanes[i].value : '0;
         any_sat = any_sat | lanes[i].sat;
      end
      sat_in = info.use_sum & any_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      if (valid) begin
         r_ff    <= r_in;
         sat_ff  <= sat_in;
         flag_ff <= info.flag & ~info.use_sum;
      end
   end

endmodule

/* rtl/quaternion_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Signed Q4.12 quaternion ALU: add, sub, Hamilton product, negate, conjugate,
// scale, add-real, dot, cross, squared norm, tolerance equality, nonzero.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Carries
//  request   in         start / busy         req_cmd, p, q, req_scalar
//  response  out        rsp_strobe (1 cycle) rsp_r_a..d, saturated, flag
//  csr       in         csr_valid/csr_ready  csr_data = equal tolerance
//
//  One request is taken per clock; busy is never raised, as no stage feeds back.
//  rsp_strobe follows the accepting edge through the decode, product,
//  sum/clip and merge registers, in that order.
//  Each lane carries four 17 x 16 multipliers, each followed by a register.
//  Synchronous active-high reset clears the valid pipe and the tolerance.
//  The receiver cannot stall, so nothing in the pipe ever waits.
//
module quaternion_arithmetic_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                start,
   output logic                                busy,
   input  logic [qau_pkg::CMD_WIDTH-1:0]       req_cmd,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_p_a,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_p_b,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_p_c,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_p_d,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_q_a,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_q_b,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_q_c,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_q_d,
   input  logic signed [qau_pkg::DATA_WIDTH-1:0] req_scalar,
   // response
   output logic                                rsp_strobe,
   output logic signed [qau_pkg::DATA_WIDTH-1:0] rsp_r_a,
   output logic signed [qau_pkg::DATA_WIDTH-1:0] rsp_r_b,
   output logic signed [qau_pkg::DATA_WIDTH-1:0] rsp_r_c,
   output logic signed [qau_pkg::DATA_WIDTH-1:0] rsp_r_d,
   output logic                                rsp_saturated,
   output logic                                rsp_flag,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qau_pkg::TOL_WIDTH-1:0]       csr_data
);
   import qau_pkg::*;

`include "quaternion_arithmetic_unit_assert.svh"

   // edges between the accept edge's successor and the strobe sample
   localparam int RSP_GAP = 3;

   logic                         accept;
   logic [TOL_WIDTH-1:0]         tol_ff;
   logic                         dec_valid;
   lane_op_type [NUM_LANES-1:0]  dec_ops;
   item_info_type                dec_info;
   logic                         mul_valid_ff;
   item_info_type                info_mul_ff;
   item_info_type                info_sum_ff;
   logic                         sum_valid_ff;
   stage_en_type                 lane_en;
   lane_res_type [NUM_LANES-1:0] lane_res;
   data_type [NUM_LANES-1:0]     r_out;

   // fully pipelined: never busy, csr always ready
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // equal tolerance register; the user must write it only while the pipe is empty (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   qau_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_cmd    (req_cmd),
      .req_p_a    (req_p_a),
      .req_p_b    (req_p_b),
      .req_p_c    (req_p_c),
      .req_p_d    (req_p_d),
      .req_q_a    (req_q_a),
      .req_q_b    (req_q_b),
      .req_q_c    (req_q_c),
      .req_q_d    (req_q_d),
      .req_scalar (req_scalar),
      .tolerance  (tol_ff),
      .valid_ff   (dec_valid),
      .ops_ff     (dec_ops),
      .info_ff    (dec_info)
   );

   // valid pipe alongside the lanes' two stages
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= dec_valid;
         sum_valid_ff <= mul_valid_ff;
      end
   end

   // per-request info rides next to the lane data
   always_ff @(posedge clock) begin
      if (dec_valid) begin
         info_mul_ff <= dec_info;
      end
      if (mul_valid_ff) begin
         info_sum_ff <= info_mul_ff;
      end
   end

   assign lane_en.mul = dec_valid;
   assign lane_en.sum = mul_valid_ff;

   // one lane per result component
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      qau_lane u_lane (
         .clock  (clock),
         .en     (lane_en),
         .op     (dec_ops[g]),
         .res_ff (lane_res[g])
      );
   end

   qau_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .valid     (sum_valid_ff),
      .lanes     (lane_res),
      .info      (info_sum_ff),
      .strobe_ff (rsp_strobe),
      .r_ff      (r_out),
      .sat_ff    (rsp_saturated),
      .flag_ff   (rsp_flag)
   );

   assign rsp_r_a = r_out[0];
   assign rsp_r_b = r_out[1];
   assign rsp_r_c = r_out[2];
   assign rsp_r_d = r_out[3];

   // every accepted request yields its response strobe
   `QAU_ASSERT_AFTER(a_rsp_latency, clock, reset, accept, RSP_GAP, rsp_strobe)
   // a test result never reports saturation
   `QAU_ASSERT_IMPLY(a_flag_no_sat, clock, reset, rsp_strobe && rsp_flag, !rsp_saturated)
   // a test result carries zero components
   `QAU_ASSERT_IMPLY(a_flag_zero, clock, reset, rsp_strobe && rsp_flag, r_out == '0)

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion arithmetic unit. A short directed
// table covers extremes, every command and the saturation and tolerance
// corners. Random requests follow under several equal-tolerance settings.
// Each response is compared lane by lane against its typed or modelled value.
// ---------------------------------------------------------------------------
module tb_top;

   import qau_pkg::*;

   // codes the command enum leaves free: the unit must answer all zeros
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_LO = 4'd12;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED_HI = 4'd15;

   // Q4.12 constants
   localparam data_type Q_ZERO    = 16'h0000;
   localparam data_type Q_LSB     = 16'h0001;
   localparam data_type Q_M_LSB   = 16'hFFFF;
   localparam data_type Q_MAX     = 16'h7FFF;
   localparam data_type Q_MIN     = 16'h8000;
   localparam data_type Q_ONE     = 16'h1000;
   localparam data_type Q_M_ONE   = 16'hF000;
   localparam data_type Q_TWO     = 16'h2000;
   localparam data_type Q_HALF    = 16'h0800;
   localparam data_type Q_QUARTER = 16'h0400;

   localparam longint SAT_HI = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (DATA_WIDTH - 1));

   // accept edge to sampling edge of the matching response
   localparam int RESULT_LATENCY  = 4;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int NUM_PHASES      = 5;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int MAX_PRINTED     = 50;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]      cmd;
      data_type [NUM_LANES-1:0]  p;
      data_type [NUM_LANES-1:0]  q;
      data_type                  s;
   } quat_request_type;

   typedef struct packed {
      data_type [NUM_LANES-1:0]  r;
      logic                      sat;
      logic                      flag;
   } quat_result_type;

   typedef struct packed {
      quat_request_type req;
      logic             typed;
      quat_result_type  want;
   } directed_row_type;

   // -------------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // -------------------------------------------------------------------------
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 start      = 1'b0;
   logic                 busy;
   logic [CMD_WIDTH-1:0] req_cmd    = '0;
   data_type             req_p_a    = '0;
   data_type             req_p_b    = '0;
   data_type             req_p_c    = '0;
   data_type             req_p_d    = '0;
   data_type             req_q_a    = '0;
   data_type             req_q_b    = '0;
   data_type             req_q_c    = '0;
   data_type             req_q_d    = '0;
   data_type             req_scalar = '0;
   logic                 rsp_strobe;
   data_type             rsp_r_a;
   data_type             rsp_r_b;
   data_type             rsp_r_c;
   data_type             rsp_r_d;
   logic                 rsp_saturated;
   logic                 rsp_flag;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [TOL_WIDTH-1:0] csr_data   = '0;

   quaternion_arithmetic_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_p_a       (req_p_a),
      .req_p_b       (req_p_b),
      .req_p_c       (req_p_c),
      .req_p_d       (req_p_d),
      .req_q_a       (req_q_a),
      .req_q_b       (req_q_b),
      .req_q_c       (req_q_c),
      .req_q_d       (req_q_d),
      .req_scalar    (req_scalar),
      .rsp_strobe    (rsp_strobe),
      .rsp_r_a       (rsp_r_a),
      .rsp_r_b       (rsp_r_b),
      .rsp_r_c       (rsp_r_c),
      .rsp_r_d       (rsp_r_d),
      .rsp_saturated (rsp_saturated),
      .rsp_flag      (rsp_flag),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   always #10 clock = ~clock;

   // -------------------------------------------------------------------------
   // Bench state
   // -------------------------------------------------------------------------
   quat_result_type      expected_results[$];  // oldest first
   logic [TOL_WIDTH-1:0] eq_tolerance = '0;    // mirror of the CSR
   int                   mismatches   = 0;
   int                   responses    = 0;
   int                   idle_cycles  = 0;
   int                   burst_left   = 0;     // requests left in a gap-free run
   quat_result_type      resp_seen;
   quat_result_type      resp_want;
   int                   lane;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("[%0t] MISMATCH %s", $realtime, what);
   endtask

   // clip to the signed data range; sets sat on clipping
   function automatic data_type clip_to_range(input longint v, inout logic sat);
      if (v > SAT_HI) begin
         sat = 1'b1;
         return data_type'(SAT_HI);
      end
      if (v < SAT_LO) begin
         sat = 1'b1;
         return data_type'(SAT_LO);
      end
      return data_type'(v);
   endfunction

   // -------------------------------------------------------------------------
   // Behavioural model of one request. Products are exact in 64 bits
   // (at most four 2^30 terms), floored by an arithmetic shift, then clipped.
   // -------------------------------------------------------------------------
   function automatic quat_result_type predict_quat_result(input quat_request_type rq);
      longint          pv [NUM_LANES];
      longint          qv [NUM_LANES];
      longint          acc[NUM_LANES];
      longint          sv;
      longint          diff;
      int              shift;
      logic            use_acc;
      quat_result_type res;
      int              i;

      res     = '0;
      shift   = 0;
      use_acc = 1'b1;
      sv      = longint'($signed(rq.s));
      for (i = 0; i < NUM_LANES; i++) begin
         pv[i]  = longint'($signed(rq.p[i]));
         qv[i]  = longint'($signed(rq.q[i]));
         acc[i] = 0;
      end

      case (rq.cmd)
         CMD_ADD: begin
            for (i = 0; i < NUM_LANES; i++) acc[i] = pv[i] + qv[i];
         end
         CMD_SUB: begin
            for (i = 0; i < NUM_LANES; i++) acc[i] = pv[i] - qv[i];
         end
         CMD_MUL: begin
            shift  = FRAC_BITS;
            acc[0] = pv[0]*qv[0] - pv[1]*qv[1] - pv[2]*qv[2] - pv[3]*qv[3];
            acc[1] = pv[0]*qv[1] + pv[1]*qv[0] + pv[2]*qv[3] - pv[3]*qv[2];
            acc[2] = pv[0]*qv[2] - pv[1]*qv[3] + pv[2]*qv[0] + pv[3]*qv[1];
            acc[3] = pv[0]*qv[3] + pv[1]*qv[2] - pv[2]*qv[1] + pv[3]*qv[0];
         end
         CMD_NEG: begin
            for (i = 0; i < NUM_LANES; i++) acc[i] = -pv[i];
         end
         CMD_CONJ: begin
            acc[0] = pv[0];
            for (i = 1; i < NUM_LANES; i++) acc[i] = -pv[i];
         end
         CMD_SCALE: begin
            shift = FRAC_BITS;
            for (i = 0; i < NUM_LANES; i++) acc[i] = pv[i] * sv;
         end
         CMD_ADDREAL: begin
            acc[0] = pv[0] + sv;
            for (i = 1; i < NUM_LANES; i++) acc[i] = pv[i];
         end
         CMD_DOT: begin
            shift  = FRAC_BITS;
            acc[0] = pv[1]*qv[1] + pv[2]*qv[2] + pv[3]*qv[3];
         end
         CMD_CROSS: begin
            shift  = FRAC_BITS;
            acc[1] = pv[2]*qv[3] - pv[3]*qv[2];
            acc[2] = pv[3]*qv[1] - pv[1]*qv[3];
            acc[3] = pv[1]*qv[2] - pv[2]*qv[1];
         end
         CMD_NORMSQ: begin
            shift  = FRAC_BITS;
            acc[0] = pv[0]*pv[0] + pv[1]*pv[1] + pv[2]*pv[2] + pv[3]*pv[3];
         end
         CMD_EQUAL: begin
            use_acc  = 1'b0;
            res.flag = 1'b1;
            for (i = 0; i < NUM_LANES; i++) begin
               diff = pv[i] - qv[i];
               if (diff < 0) diff = -diff;
               if (diff > longint'(eq_tolerance)) res.flag = 1'b0;
            end
         end
         CMD_NONZERO: begin
            use_acc  = 1'b0;
            res.flag = (rq.p != '0);
         end
         default: begin
            use_acc = 1'b0;
         end
      endcase

      if (use_acc)
         for (i = 0; i < NUM_LANES; i++)
            res.r[i] = clip_to_range(acc[i] >>> shift, res.sat);
      return res;
   endfunction

   // one line of the directed table; expectation typed only where obvious
   function automatic directed_row_type stim_row(
      input logic [CMD_WIDTH-1:0] cmd,
      input data_type pa, input data_type pb, input data_type pc, input data_type pd,
      input data_type qa, input data_type qb, input data_type qc, input data_type qd,
      input data_type sc,
      input logic typed = 1'b0,
      input data_type ra = '0, input data_type rb = '0,
      input data_type rc = '0, input data_type rd = '0,
      input logic sat = 1'b0, input logic flag = 1'b0);
      directed_row_type row;
      row.req.cmd   = cmd;
      row.req.p     = {pd, pc, pb, pa};
      row.req.q     = {qd, qc, qb, qa};
      row.req.s     = sc;
      row.typed     = typed;
      row.want.r    = {rd, rc, rb, ra};
      row.want.sat  = sat;
      row.want.flag = flag;
      return row;
   endfunction

   // -------------------------------------------------------------------------
   // Random stimulus
   // -------------------------------------------------------------------------
   // mostly small values near unity, plenty of full-range, some extremes
   function automatic data_type rand_q12();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return Q_MAX;
               1:       return Q_MIN;
               2:       return Q_ZERO;
               3:       return Q_LSB;
               default: return Q_M_LSB;
            endcase
         end
         1, 2, 3: return data_type'($urandom);
         default: return data_type'($urandom_range(0, 16383) - 8192);
      endcase
   endfunction

   function automatic quat_request_type gen_random_request();
      quat_request_type rq;
      int               span;
      int               i;

      if ($urandom_range(0, 99) < 4)
         rq.cmd = CMD_UNUSED_LO + CMD_WIDTH'($urandom_range(0, 3));
      else
         rq.cmd = CMD_WIDTH'($urandom_range(CMD_ADD, CMD_NONZERO));
      for (i = 0; i < NUM_LANES; i++) begin
         rq.p[i] = rand_q12();
         rq.q[i] = rand_q12();
      end
      rq.s = rand_q12();

      // equality is only interesting with q hovering round the tolerance
      if (rq.cmd == CMD_EQUAL && $urandom_range(0, 9) < 7) begin
         span = int'(eq_tolerance) + 2;
         for (i = 0; i < NUM_LANES; i++)
            rq.q[i] = rq.p[i] + data_type'($urandom_range(0, 2 * span) - span);
      end
      // nonzero test: zero vectors and single-lane vectors
      if (rq.cmd == CMD_NONZERO && $urandom_range(0, 2) == 0) begin
         rq.p = '0;
         if ($urandom_range(0, 1) == 1) rq.p[$urandom_range(0, 3)] = rand_q12();
      end
      return rq;
   endfunction

   // sender gap: mostly none or short, a few long, plus gap-free runs
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // -------------------------------------------------------------------------
   // Request side. Called at a rising edge; returns at the accepting edge
   // with start still high, so back-to-back requests never drop it.
   // -------------------------------------------------------------------------
   task automatic issue_request(input quat_request_type rq, input logic typed,
                                input quat_result_type typed_want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_cmd    <= rq.cmd;
      req_p_a    <= rq.p[0];
      req_p_b    <= rq.p[1];
      req_p_c    <= rq.p[2];
      req_p_d    <= rq.p[3];
      req_q_a    <= rq.q[0];
      req_q_b    <= rq.q[1];
      req_q_c    <= rq.q[2];
      req_q_d    <= rq.q[3];
      req_scalar <= rq.s;
      do @(posedge clock); while (busy);
      expected_results.push_back(typed ? typed_want : predict_quat_result(rq));
   endtask

   // hold off until every outstanding response is back and the pipe is empty
   task automatic wait_until_drained();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY) @(posedge clock);
   endtask

   // only ever called with the unit drained
   task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      eq_tolerance  = value;
   endtask

   // -------------------------------------------------------------------------
   // Response checker and watchdog. Runs on the same edge the DUT updates,
   // so it sees the values held during the cycle just ended.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            responses++;
            resp_seen.r    = {rsp_r_d, rsp_r_c, rsp_r_b, rsp_r_a};
            resp_seen.sat  = rsp_saturated;
            resp_seen.flag = rsp_flag;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                         responses));
            end else begin
               resp_want = expected_results.pop_front();
               for (lane = 0; lane < NUM_LANES; lane++)
                  if (resp_seen.r[lane] !== resp_want.r[lane])
                     report_mismatch($sformatf("response %0d r_%c: got %0d, expected %0d",
                                               responses, 8'h61 + lane,
                                               $signed(resp_seen.r[lane]),
                                               $signed(resp_want.r[lane])));
               if (resp_seen.sat !== resp_want.sat)
                  report_mismatch($sformatf("response %0d saturated: got %b, expected %b",
                                            responses, resp_seen.sat, resp_want.sat));
               if (resp_seen.flag !== resp_want.flag)
                  report_mismatch($sformatf("response %0d flag: got %b, expected %b",
                                            responses, resp_seen.flag, resp_want.flag));
            end
         end

         // watchdog: any handshake on any channel counts as progress
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("quaternion_arithmetic_unit regression: fail");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus sequence
   // -------------------------------------------------------------------------
   initial begin
      directed_row_type     rows[$];
      logic [TOL_WIDTH-1:0] tol;
      int                   ph;
      int                   n;
      int                   k;

      // ---- directed table, tolerance at its reset value of zero ----------
      // add: all zero, then all operands at the maximum, saturating upwards
      rows.push_back(stim_row(CMD_ADD, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1));
      rows.push_back(stim_row(CMD_ADD, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                              Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_ZERO,
                              1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
      // sub: min - max clips downwards
      rows.push_back(stim_row(CMD_SUB, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                              Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_ZERO,
                              1'b1, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
      // negating the most negative value saturates to the largest
      rows.push_back(stim_row(CMD_NEG, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                              1'b1, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
      // conjugate: real part passes, vector part negated (one lane clips)
      rows.push_back(stim_row(CMD_CONJ, Q_MIN, Q_MIN, Q_MAX, Q_LSB,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                              1'b1, Q_MIN, Q_MAX, 16'h8001, Q_M_LSB, 1'b1));
      // Hamilton product: identity, i*j = k, all operands at the minimum
      rows.push_back(stim_row(CMD_MUL, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                              Q_MIN, Q_MAX, Q_HALF, Q_M_LSB, Q_ZERO));
      rows.push_back(stim_row(CMD_MUL, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO,
                              Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO,
                              1'b1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, 1'b0));
      rows.push_back(stim_row(CMD_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                              Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_ZERO));
      // scale: by one is exact, by one LSB floors towards minus infinity
      rows.push_back(stim_row(CMD_SCALE, Q_MAX, Q_MIN, Q_LSB, Q_M_LSB,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE,
                              1'b1, Q_MAX, Q_MIN, Q_LSB, Q_M_LSB, 1'b0));
      rows.push_back(stim_row(CMD_SCALE, Q_LSB, Q_M_LSB, Q_LSB, Q_M_LSB,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_LSB,
                              1'b1, Q_ZERO, Q_M_LSB, Q_ZERO, Q_M_LSB, 1'b0));
      rows.push_back(stim_row(CMD_SCALE, Q_MIN, Q_MAX, Q_TWO, Q_M_ONE,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN));
      // add real: only the real lane moves, and it clips
      rows.push_back(stim_row(CMD_ADDREAL, Q_MAX, Q_MIN, Q_LSB, Q_M_LSB,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_LSB,
                              1'b1, Q_MAX, Q_MIN, Q_LSB, Q_M_LSB, 1'b1));
      // dot: real parts ignored; 0.5 + 0.5 - 1.0 = 0
      rows.push_back(stim_row(CMD_DOT, Q_MAX, Q_ONE, Q_TWO, Q_M_ONE,
                              Q_MIN, Q_HALF, Q_QUARTER, Q_ONE, Q_ZERO, 1'b1));
      rows.push_back(stim_row(CMD_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                              Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_ZERO,
                              1'b1, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1));
      // cross: i x j = k with real parts ignored, then extremes
      rows.push_back(stim_row(CMD_CROSS, Q_MAX, Q_ONE, Q_ZERO, Q_ZERO,
                              Q_MIN, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO,
                              1'b1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, 1'b0));
      rows.push_back(stim_row(CMD_CROSS, Q_ZERO, Q_MAX, Q_MIN, Q_MAX,
                              Q_ZERO, Q_MIN, Q_MAX, Q_MIN, Q_ZERO));
      // squared norm
      rows.push_back(stim_row(CMD_NORMSQ, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO,
                              Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_ZERO,
                              1'b1, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0));
      rows.push_back(stim_row(CMD_NORMSQ, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                              1'b1, Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1));
      // equality at zero tolerance: identical, opposite extremes, one LSB off
      rows.push_back(stim_row(CMD_EQUAL, Q_MAX, Q_MIN, Q_ZERO, Q_LSB,
                              Q_MAX, Q_MIN, Q_ZERO, Q_LSB, Q_ZERO,
                              1'b1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b1));
      rows.push_back(stim_row(CMD_EQUAL, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                              Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_ZERO, 1'b1));
      rows.push_back(stim_row(CMD_EQUAL, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_LSB, Q_ZERO, 1'b1));
      // nonzero test
      rows.push_back(stim_row(CMD_NONZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                              Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1));
      rows.push_back(stim_row(CMD_NONZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MIN,
                              Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                              1'b1, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 1'b1));
      // free command codes answer all zeros
      rows.push_back(stim_row(CMD_UNUSED_LO, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                              Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1));
      rows.push_back(stim_row(CMD_UNUSED_HI, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                              Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));

      // single reset, held from time zero
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < rows.size(); k++)
         issue_request(rows[k].req, rows[k].typed, rows[k].want);

      // ---- random phases, each under its own tolerance -------------------
      // first phase keeps the reset tolerance; then max, one LSB, random, zero
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            case (ph)
               1:       tol = '1;
               2:       tol = TOL_WIDTH'(1);
               3:       tol = TOL_WIDTH'($urandom_range(2, 254));
               default: tol = '0;
            endcase
            wait_until_drained();
            write_tolerance(tol);
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // occasional full drain mid-stream, and one guaranteed
            if ((ph == 2 && n == ITEMS_PER_PHASE / 2) || $urandom_range(0, 199) == 0)
               wait_until_drained();
            issue_request(gen_random_request(), 1'b0, '0);
         end
      end

      wait_until_drained();
      repeat (RESULT_LATENCY) @(posedge clock);

      if (mismatches == 0)
         $display("quaternion_arithmetic_unit regression: pass");
      else
         $display("quaternion_arithmetic_unit regression: fail");
      $finish;
   end

endmodule
